// ----- hw/rtl/abm_pkg.sv -----
// ----------------------------------------------------------------------------
// abm_pkg
// Shared types, codes and the quarter-wave sine generator of the ASK/BPSK
// modulator.
// ----------------------------------------------------------------------------
package abm_pkg;

  // carrier phase and sine table geometry
  localparam int PHASE_W   = 16;
  localparam int SINE_BITS = 8;
  localparam int QBITS     = SINE_BITS - 2;
  localparam int QLEN      = 1 << QBITS;
  localparam int MAG_W     = 15;
  localparam int SAMPLE_W  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPS        = 8'd3;

  // symbol codes on the input
  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;

  // keying modes
  localparam logic MODE_ASK  = 1'b0;
  localparam logic MODE_BPSK = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_HALF = 2'd2
  } sym_class_t;

  typedef struct packed {
    sym_class_t cls;
    logic       eof;
  } entry_t;

  typedef struct packed {
    logic issue;
    logic last;
  } seq_status_t;

  // Magnitude of sin(pi/2 * u/QLEN) in Q15 by a Q30 Taylor series; used with
  // constant arguments only, to build the quarter-wave table.
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned y;
    longint unsigned m;
    x  = 64'(u) << (30 - QBITS);
    x2 = (x * x) >> 30;
    p  = 64'd5026996 - ((x2 * 64'd172272) >> 30);
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    y  = (x * p) >> 30;
    m  = (y + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return m[MAG_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/ask_bpsk_modulator_unit.sv -----
// ----------------------------------------------------------------------------
// ask_bpsk_modulator_unit
// ASK / BPSK carrier modulator: each symbol request yields a burst of
// samples from a phase accumulator, cleared after each frame, and a sine table.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  in       | in_valid/in_ready   | symbol, end_of_frame
//  out      | out_valid/out_ready | sample, last_of_symbol
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A symbol occupies samples_per_symbol samples (0 read as 1, capped at
//  MAX_SAMPLES_PER_SYMBOL), one sample a cycle from the head-of-queue sequencer
//  unless out stalls; samples pass address, magnitude, product and output regs.
//  Reset restores the register defaults, clears the phase and empties the queue.
//  out_ready low with a sample waiting freezes the sample pipeline; requests
//  are still taken until the two-entry queue is full.
// ----------------------------------------------------------------------------
module ask_bpsk_modulator_unit #(
  parameter int MAX_SAMPLES_PER_SYMBOL = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       symbol,
  input  logic                             end_of_frame,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               sample,
  output logic                             last_of_symbol,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [abm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_SAMPLES_PER_SYMBOL + 1);
  localparam int QW = $bits(abm_pkg::entry_t) + CW;

  logic                              mode;
  logic [abm_pkg::MAG_W-1:0]         amplitude;
  logic [abm_pkg::PHASE_W-1:0]       phase_step;
  logic [6:0]                        sps;

  logic                              q_push;
  logic                              q_ready;
  logic                              q_pop;
  logic                              q_valid;
  abm_pkg::entry_t                   push_entry;
  logic [CW-1:0]                     push_cnt;
  logic [QW-1:0]                     head_data;
  abm_pkg::entry_t                   head_entry;
  logic [CW-1:0]                     head_cnt;
  abm_pkg::seq_status_t              seq_st;
  logic [abm_pkg::SAMPLE_W-1:0]      sample_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= abm_pkg::MODE_ASK;
      amplitude  <= 15'd16384;
      phase_step <= 16'd4096;
      sps        <= 7'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        abm_pkg::REG_MODE:       mode       <= cfg_data[0];
        abm_pkg::REG_AMPLITUDE:  amplitude  <= cfg_data[abm_pkg::MAG_W-1:0];
        abm_pkg::REG_PHASE_STEP: phase_step <= cfg_data;
        abm_pkg::REG_SPS:        sps        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  abm_front #(
    .MAX_SPS (MAX_SAMPLES_PER_SYMBOL),
    .CW      (CW)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .symbol       (symbol),
    .end_of_frame (end_of_frame),
    .sps          (sps),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_entry      (push_entry),
    .q_cnt        (push_cnt)
  );

  abm_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({push_entry, push_cnt}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  assign head_entry = abm_pkg::entry_t'(head_data[QW-1:CW]);
  assign head_cnt   = head_data[CW-1:0];

  abm_back #(
    .CW (CW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (head_entry),
    .q_cnt          (head_cnt),
    .q_pop          (q_pop),
    .mode           (mode),
    .amplitude      (amplitude),
    .phase_step     (phase_step),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample_bits),
    .last_of_symbol (last_of_symbol),
    .status         (seq_st)
  );

  assign sample = $signed(sample_bits);

`ifndef NO_ASSERTIONS
  a_issue_needs_request: assert property (@(posedge clk) disable iff (rst)
    seq_st.issue |-> q_valid)
    else $error("sample issued with empty request queue");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop == (seq_st.issue && seq_st.last))
    else $error("request retired other than on its last sample");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> in_ready)
    else $error("input stalled with empty queue");
`endif

endmodule

// ----- hw/rtl/abm_front.sv -----
// ----------------------------------------------------------------------------
// abm_front
// Takes symbol requests, classifies the symbol code and fixes the sample
// count of the symbol before it enters the queue.
// ----------------------------------------------------------------------------
module abm_front #(
  parameter int MAX_SPS = 64,
  parameter int CW      = 7
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           symbol,
  input  logic                 end_of_frame,
  input  logic [6:0]           sps,
  input  logic                 q_ready,
  output logic                 q_push,
  output abm_pkg::entry_t      q_entry,
  output logic [CW-1:0]        q_cnt
);

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    q_entry.eof = end_of_frame;
    unique case (symbol)
      abm_pkg::SYM_ZERO: q_entry.cls = abm_pkg::CLS_ZERO;
      abm_pkg::SYM_ONE:  q_entry.cls = abm_pkg::CLS_ONE;
      default:           q_entry.cls = abm_pkg::CLS_HALF;
    endcase
  end

  // zero counts as one, anything above the limit saturates
  always_comb begin
    if (sps > 7'(MAX_SPS)) begin
      q_cnt = CW'(MAX_SPS);
    end else if (sps == 7'd0) begin
      q_cnt = CW'(1);
    end else begin
      q_cnt = CW'(sps);
    end
  end

endmodule

// ----- hw/rtl/abm_fifo.sv -----
// ----------------------------------------------------------------------------
// abm_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module abm_fifo #(
  parameter int WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = abm_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != FW'(DEPTH));
  assign head_valid = (fill != FW'(0));
  assign head_data  = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/abm_back.sv -----
// ----------------------------------------------------------------------------
// abm_back
// Sample sequencer and carrier datapath: phase accumulator, quarter-wave
// sine table, amplitude multiply, keying and saturation.
// ----------------------------------------------------------------------------
module abm_back #(
  parameter int CW = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  abm_pkg::entry_t                q_entry,
  input  logic [CW-1:0]                  q_cnt,
  output logic                           q_pop,
  input  logic                           mode,
  input  logic [abm_pkg::MAG_W-1:0]      amplitude,
  input  logic [abm_pkg::PHASE_W-1:0]    phase_step,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [abm_pkg::SAMPLE_W-1:0]   sample,
  output logic                           last_of_symbol,
  output abm_pkg::seq_status_t           status
);

  localparam int AW = abm_pkg::SINE_BITS;
  localparam int QB = abm_pkg::QBITS;
  localparam int MW = abm_pkg::MAG_W;
  localparam int PW = 2 * abm_pkg::MAG_W;

  // quarter-wave magnitude table, QLEN + 1 entries
  logic [MW-1:0] sine_rom [abm_pkg::QLEN + 1];

  for (genvar g = 0; g <= abm_pkg::QLEN; g++) begin : g_rom
    localparam logic [MW-1:0] MAG = abm_pkg::sine_mag(g);
    assign sine_rom[g] = MAG;
  end

  logic                        adv;
  logic                        issue;
  logic                        last;
  logic [CW-1:0]               idx;
  logic [abm_pkg::PHASE_W-1:0] phase_acc;

  // stage 1: table address
  logic                        v1;
  logic [AW-1:0]               s1_addr;
  abm_pkg::sym_class_t         s1_cls;
  logic                        s1_last;
  // stage 2: magnitude
  logic                        v2;
  logic [MW-1:0]               s2_mag;
  logic                        s2_neg;
  abm_pkg::sym_class_t         s2_cls;
  logic                        s2_last;
  // stage 3: product
  logic                        v3;
  logic [PW-1:0]               s3_prod;
  logic                        s3_neg;
  logic                        s3_half;
  logic                        s3_zero;
  logic                        s3_last;

  logic [QB:0]                 rom_idx;
  logic                        s2_neg_next;
  logic signed [PW:0]          signed_prod;
  logic signed [PW:0]          shifted;
  logic [abm_pkg::SAMPLE_W-1:0] sample_next;

  // whole pipe holds while a finished sample waits
  assign adv    = !out_valid || out_ready;
  assign issue  = adv && q_valid;
  assign last   = (idx == q_cnt - CW'(1));
  assign q_pop  = issue && last;
  assign status = '{issue: issue, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      phase_acc <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
      if (q_valid) begin
        idx <= last ? '0 : idx + CW'(1);
        // restart the carrier after the last sample of a frame
        phase_acc <= (last && q_entry.eof) ? '0 : phase_acc + phase_step;
      end
    end
  end

  always_comb begin
    if (s1_addr[QB]) begin
      rom_idx = (QB + 1)'(abm_pkg::QLEN) - {1'b0, s1_addr[QB-1:0]};
    end else begin
      rom_idx = {1'b0, s1_addr[QB-1:0]};
    end
  end

  always_comb begin
    s2_neg_next = s2_neg;
    if (s2_cls == abm_pkg::CLS_ZERO) begin
      s2_neg_next = !s2_neg;
    end
  end

  always_comb begin
    signed_prod = s3_neg ? -$signed({1'b0, s3_prod}) : $signed({1'b0, s3_prod});
    shifted     = s3_half ? (signed_prod >>> 16) : (signed_prod >>> 15);
    if (s3_zero) begin
      sample_next = '0;
    end else if (shifted > (PW + 1)'(32767)) begin
      sample_next = 16'h7fff;
    end else if (shifted < -(PW + 1)'(32768)) begin
      sample_next = 16'h8000;
    end else begin
      sample_next = shifted[abm_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr        <= phase_acc[abm_pkg::PHASE_W-1 -: AW];
      s1_cls         <= q_entry.cls;
      s1_last        <= last;
      s2_mag         <= sine_rom[rom_idx];
      s2_neg         <= s1_addr[AW-1];
      s2_cls         <= s1_cls;
      s2_last        <= s1_last;
      s3_prod        <= PW'(amplitude) * PW'(s2_mag);
      s3_neg         <= s2_neg_next;
      s3_half        <= (s2_cls == abm_pkg::CLS_HALF);
      s3_zero        <= (s2_cls == abm_pkg::CLS_ZERO) && (mode == abm_pkg::MODE_ASK);
      s3_last        <= s2_last;
      sample         <= sample_next;
      last_of_symbol <= s3_last;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ASK/BPSK modulator. A local model tracks the
// phase accumulator and registers, predicts every sample burst from each
// symbol request and checks the sample stream under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          MAX_SPS    = 64;
  localparam int          QTR        = 64;
  localparam logic [1:0]  SYM_BAD_2  = 2'd2;
  localparam logic [1:0]  SYM_BAD_3  = 2'd3;
  localparam int          PHASE_GAP  = 12;

  typedef struct {
    logic [1:0] sym;
    logic       eof;
  } symbol_req_t;

  typedef struct {
    logic signed [15:0] smp;
    logic               last;
  } carrier_sample_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     symbol = 2'd0;
  logic                           end_of_frame = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [15:0]             sample;
  logic                           last_of_symbol;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [abm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [abm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // local copy of the block's registers and phase
  logic        m_mode  = abm_pkg::MODE_ASK;
  logic [14:0] m_amp   = 15'd16384;
  logic [15:0] m_step  = 16'd4096;
  logic [6:0]  m_sps   = 7'd16;
  logic [15:0] m_phase = 16'd0;

  symbol_req_t     symbols_todo[$];
  carrier_sample_t samples_due[$];
  logic            in_taken = 1'b0;
  int              mismatches = 0;
  int              tx_idle = 0;
  int              rx_idle = 0;
  int              hold_req = 0;
  int              held = 0;

  ask_bpsk_modulator_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .symbol         (symbol),
    .end_of_frame   (end_of_frame),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .last_of_symbol (last_of_symbol),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Q15 sine of an 8-bit table address, quarter-wave Taylor series in Q30
  function automatic int carrier_sine(input logic [7:0] addr);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned y;
    longint unsigned mag;
    int unsigned     u;
    u   = addr[6] ? (QTR - int'(addr[5:0])) : int'(addr[5:0]);
    x   = longint'(u) << 24;
    x2  = (x * x) >> 30;
    p   = 64'd5026996 - ((x2 * 64'd172272) >> 30);
    p   = 64'd85569306 - ((x2 * p) >> 30);
    p   = 64'd693598668 - ((x2 * p) >> 30);
    p   = 64'd1686629713 - ((x2 * p) >> 30);
    y   = (x * p) >> 30;
    mag = (y + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return addr[7] ? -int'(mag) : int'(mag);
  endfunction

  function automatic void predict_burst(input logic [1:0] sym, input logic eof);
    int              n;
    int              s;
    longint          v;
    carrier_sample_t e;
    n = (m_sps == 7'd0) ? 1 : ((int'(m_sps) > MAX_SPS) ? MAX_SPS : int'(m_sps));
    for (int i = 0; i < n; i++) begin
      s = carrier_sine(m_phase[15:8]);
      if (sym == abm_pkg::SYM_ONE) begin
        v = (longint'(m_amp) * s) >>> 15;
      end else if (sym == abm_pkg::SYM_ZERO) begin
        v = (m_mode == abm_pkg::MODE_BPSK) ? ((longint'(m_amp) * -s) >>> 15) : 64'sd0;
      end else begin
        v = (longint'(m_amp) * s) >>> 16;
      end
      if (v > 32767) begin
        v = 32767;
      end else if (v < -32768) begin
        v = -32768;
      end
      e.smp  = v[15:0];
      e.last = (i == n - 1);
      samples_due.push_back(e);
      m_phase = m_phase + m_step;
    end
    if (eof) begin
      m_phase = 16'd0;
    end
  endfunction

  // model update and sample check
  always @(posedge clk) begin
    carrier_sample_t e;
    in_taken <= in_valid && in_ready;
    if (rst) begin
      m_mode  = abm_pkg::MODE_ASK;
      m_amp   = 15'd16384;
      m_step  = 16'd4096;
      m_sps   = 7'd16;
      m_phase = 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          abm_pkg::REG_MODE:       m_mode = cfg_data[0];
          abm_pkg::REG_AMPLITUDE:  m_amp  = cfg_data[14:0];
          abm_pkg::REG_PHASE_STEP: m_step = cfg_data;
          abm_pkg::REG_SPS:        m_sps  = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_burst(symbol, end_of_frame);
      end
      if (out_valid && out_ready) begin
        if (samples_due.size() == 0) begin
          $display("%0t: sample with none due: expected none, actual %0d last %0b",
                   $time, sample, last_of_symbol);
          mismatches++;
        end else begin
          e = samples_due.pop_front();
          if (sample !== e.smp) begin
            $display("%0t: sample: expected %0d, actual %0d", $time, e.smp, sample);
            mismatches++;
          end
          if (last_of_symbol !== e.last) begin
            $display("%0t: last_of_symbol: expected %0b, actual %0b",
                     $time, e.last, last_of_symbol);
            mismatches++;
          end
        end
      end
    end
  end

  // symbol driver: hold the request until taken, then maybe idle
  always @(negedge clk) begin
    symbol_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (symbols_todo.size() != 0 && $urandom_range(99) >= tx_idle) begin
        r = symbols_todo.pop_front();
        in_valid     <= 1'b1;
        symbol       <= r.sym;
        end_of_frame <= r.eof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sample receiver; a pending hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (held < hold_req) begin
      out_ready <= 1'b0;
      held      <= held + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic write_reg(input logic [abm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [abm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [15:0] mode_d, input logic [15:0] amp_d,
                           input logic [15:0] step_d, input logic [15:0] sps_d,
                           input logic [abm_pkg::CFG_IDX_W-1:0] spare_idx);
    write_reg(abm_pkg::REG_MODE, mode_d);
    write_reg(abm_pkg::REG_AMPLITUDE, amp_d);
    write_reg(abm_pkg::REG_PHASE_STEP, step_d);
    write_reg(abm_pkg::REG_SPS, sps_d);
    // index past the last register: must be dropped
    write_reg(spare_idx, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_symbol(input logic [1:0] sym, input logic eof);
    symbols_todo.push_back('{sym, eof});
  endtask

  task automatic drain();
    while (symbols_todo.size() != 0 || in_valid || samples_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PHASE_GAP) @(posedge clk);
  endtask

  initial begin
    int          pick;
    logic [1:0]  sym;
    logic [15:0] sps_d;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle = 15;
    rx_idle = 73;

    // reset defaults: ASK, half-scale carrier
    add_symbol(abm_pkg::SYM_ZERO, 1'b0);
    add_symbol(abm_pkg::SYM_ONE, 1'b0);
    add_symbol(SYM_BAD_2, 1'b0);
    add_symbol(SYM_BAD_3, 1'b1);
    add_symbol(abm_pkg::SYM_ONE, 1'b0);
    drain();

    // full scale, top phase step, one sample per symbol, masked upper bits
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 8'hFF);
    add_symbol(abm_pkg::SYM_ZERO, 1'b0);
    add_symbol(abm_pkg::SYM_ONE, 1'b0);
    add_symbol(SYM_BAD_2, 1'b1);
    add_symbol(SYM_BAD_3, 1'b0);
    add_symbol(abm_pkg::SYM_ONE, 1'b1);
    add_symbol(abm_pkg::SYM_ZERO, 1'b0);
    drain();

    // zero samples per symbol reads as one, frozen phase
    configure(16'h0000, 16'd32767, 16'd0, 16'h0000, 8'd4);
    add_symbol(abm_pkg::SYM_ONE, 1'b0);
    add_symbol(abm_pkg::SYM_ZERO, 1'b0);
    add_symbol(SYM_BAD_2, 1'b0);
    add_symbol(SYM_BAD_3, 1'b1);
    drain();

    // oversized count caps at the maximum, zero amplitude
    configure(16'h0001, 16'h0000, 16'h8000, 16'h00FF, 8'h80);
    add_symbol(abm_pkg::SYM_ONE, 1'b0);
    add_symbol(abm_pkg::SYM_ZERO, 1'b1);
    drain();

    configure(16'h0001, 16'h4000, 16'd1, 16'd64, 8'h7F);
    add_symbol(abm_pkg::SYM_ZERO, 1'b0);
    add_symbol(abm_pkg::SYM_ONE, 1'b1);
    add_symbol(SYM_BAD_2, 1'b0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 3) begin
        tx_idle = 15;
        rx_idle = 73;
      end else if (ph < 6) begin
        tx_idle = 73;
        rx_idle = 15;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      case (ph)
        3:       sps_d = {9'($urandom), 7'd64};
        8:       sps_d = 16'hFF80;
        9:       sps_d = {9'($urandom), 7'd100};
        default: sps_d = {9'($urandom), 7'($urandom_range(1, 12))};
      endcase
      configure(16'($urandom), 16'($urandom), 16'($urandom), sps_d,
                8'($urandom_range(int'(abm_pkg::REG_SPS) + 1, 255)));
      // long receiver hold-off while the sender keeps pushing
      if (ph == 6) begin
        hold_req = held + 300;
      end
      repeat (41) begin
        pick = $urandom_range(9);
        sym  = (pick < 4) ? abm_pkg::SYM_ZERO : (pick < 8) ? abm_pkg::SYM_ONE :
               (pick == 8) ? SYM_BAD_2 : SYM_BAD_3;
        add_symbol(sym, $urandom_range(7) == 0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
